>>> hdl/bounded_multi_stack_allocator_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bounded multi-stack allocator
// Shared property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_MULTI_STACK_ALLOCATOR_UNIT_DEFINES_SVH
`define BOUNDED_MULTI_STACK_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BMSA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BMSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/bmsa_pkg.sv
// ---------------------------------------------------------------------------
// bmsa_pkg
// Shared constants, codes and the stack selection record.
// ---------------------------------------------------------------------------
package bmsa_pkg;

  // Default geometry.
  localparam int NUM_STACKS_DEF = 16;
  localparam int MAX_DEPTH_DEF  = 16;
  localparam int VALUE_BITS_DEF = 32;

  // Widest stack number and slot number over the legal parameter ranges.
  localparam int STACK_BITS = 8;
  localparam int SLOT_BITS  = 10;

  // Reset value of the capacity register.
  localparam logic [4:0] CAPACITY_RESET = 5'd16;

  // Request command codes.
  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_POP_AT = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Outcome of the stack selection for one request.
  typedef struct packed {
    logic                  hit;
    logic [STACK_BITS-1:0] stack;
    logic [SLOT_BITS-1:0]  slot;
  } sel_t;

endpackage

>>> hdl/bmsa_plate_ram.sv
// ---------------------------------------------------------------------------
// bmsa_plate_ram
// Single-port plate memory with a registered read port.
// ---------------------------------------------------------------------------
module bmsa_plate_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle: a write or a registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> hdl/bmsa_fill_ctrl.sv
// ---------------------------------------------------------------------------
// bmsa_fill_ctrl
// Per-stack fill counts, full and non-empty flags, and stack selection.
// ---------------------------------------------------------------------------
module bmsa_fill_ctrl #(
  parameter int NUM_STACKS = bmsa_pkg::NUM_STACKS_DEF,
  parameter int MAX_DEPTH  = bmsa_pkg::MAX_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [1:0]       command,
  input  logic [7:0]       stack_index,
  input  logic [4:0]       capacity,
  output bmsa_pkg::sel_t   sel
);

  localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int FW = $clog2(MAX_DEPTH + 1);
  localparam int CW = (FW > 5) ? FW : 5;

  logic [FW-1:0]         fill [NUM_STACKS];
  logic [NUM_STACKS-1:0] not_full;
  logic [NUM_STACKS-1:0] not_empty;
  logic [CW-1:0]         cap_ext;
  logic [CW-1:0]         cap_eff;
  logic [SW-1:0]         push_stack;
  logic                  push_found;
  logic [SW-1:0]         pop_stack;
  logic                  pop_found;
  logic                  at_in_range;
  logic [SW-1:0]         sel_stack;
  logic                  sel_hit;
  logic [FW-1:0]         sel_fill;
  logic [FW-1:0]         sel_slot;

  // Capacity in use: zero counts as one, large values saturate at the depth.
  assign cap_ext = CW'(capacity);
  always_comb begin
    if (capacity == 5'd0) begin
      cap_eff = CW'(1);
    end else if (cap_ext > CW'(MAX_DEPTH)) begin
      cap_eff = CW'(MAX_DEPTH);
    end else begin
      cap_eff = cap_ext;
    end
  end

  // Per-stack flags. A stack at or above the capacity counts as full.
  always_comb begin
    for (int i = 0; i < NUM_STACKS; i++) begin
      not_full[i]  = CW'(fill[i]) < cap_eff;
      not_empty[i] = fill[i] != '0;
    end
  end

  // Leftmost stack with room: scan downward so the lowest index wins.
  always_comb begin
    push_stack = '0;
    push_found = 1'b0;
    for (int i = NUM_STACKS - 1; i >= 0; i--) begin
      if (not_full[i]) begin
        push_stack = SW'(i);
        push_found = 1'b1;
      end
    end
  end

  // Rightmost non-empty stack: scan upward so the highest index wins.
  always_comb begin
    pop_stack = '0;
    pop_found = 1'b0;
    for (int i = 0; i < NUM_STACKS; i++) begin
      if (not_empty[i]) begin
        pop_stack = SW'(i);
        pop_found = 1'b1;
      end
    end
  end

  assign at_in_range = 32'(stack_index) < 32'(NUM_STACKS);

  // Pick the stack the request works on.
  always_comb begin
    sel_stack = '0;
    sel_hit   = 1'b0;
    case (command)
      bmsa_pkg::CMD_PUSH: begin
        sel_stack = push_stack;
        sel_hit   = push_found;
      end
      bmsa_pkg::CMD_POP: begin
        sel_stack = pop_stack;
        sel_hit   = pop_found;
      end
      bmsa_pkg::CMD_POP_AT: begin
        if (at_in_range) begin
          sel_stack = stack_index[SW-1:0];
          sel_hit   = not_empty[stack_index[SW-1:0]];
        end
      end
      default: begin
        sel_stack = '0;
        sel_hit   = 1'b0;
      end
    endcase
  end

  // Slot touched: the free slot for a push, the top slot for a pop.
  assign sel_fill = fill[sel_stack];
  assign sel_slot = (command == bmsa_pkg::CMD_PUSH) ? sel_fill : sel_fill - FW'(1);

  assign sel.hit   = sel_hit;
  assign sel.stack = bmsa_pkg::STACK_BITS'(sel_stack);
  assign sel.slot  = bmsa_pkg::SLOT_BITS'(sel_slot);

  // Fill count update on an accepted request that found its stack.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        fill[i] <= '0;
      end
    end else if (accept && sel_hit) begin
      if (command == bmsa_pkg::CMD_PUSH) begin
        fill[sel_stack] <= sel_fill + FW'(1);
      end else begin
        fill[sel_stack] <= sel_slot;
      end
    end
  end

endmodule

>>> hdl/bounded_multi_stack_allocator_unit.sv
// ---------------------------------------------------------------------------
// bounded_multi_stack_allocator_unit
// Row of equal-capacity plate stacks with push, pop and pop-at requests.
// ---------------------------------------------------------------------------
// A request is accepted when start is high and busy is low; at that edge the
// stack is chosen and the plate memory written or read. The result appears
// with done high for exactly one cycle in the next cycle, while busy is high;
// it comes from the registered read port of the single-port plate memory.
// The receiver cannot stall; the result must be taken in the cycle done is
// high. The user must write the capacity register over the APB port only
// while no request is in flight; the block does not enforce this.
module bounded_multi_stack_allocator_unit #(
  parameter int NUM_STACKS = bmsa_pkg::NUM_STACKS_DEF,
  parameter int MAX_DEPTH  = bmsa_pkg::MAX_DEPTH_DEF,
  parameter int VALUE_BITS = bmsa_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // Request channel.
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command,
  input  logic signed [31:0] push_value,
  input  logic [7:0]         stack_index,
  // Result channel.
  output logic               done,
  output logic signed [31:0] popped_value,
  output logic [1:0]         status,
  output logic [3:0]         placed_stack,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int DEPTH = NUM_STACKS * MAX_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                  accept;
  logic [4:0]            capacity;
  bmsa_pkg::sel_t        sel;
  logic                  mem_we;
  logic                  mem_re;
  logic [AW-1:0]         mem_addr;
  logic [VALUE_BITS-1:0] mem_wdata;
  logic [VALUE_BITS-1:0] mem_rdata;
  logic                  res_pop;
  logic [1:0]            res_status;
  logic [3:0]            res_stack;
  logic [1:0]            status_next;
  logic                  is_push;
  logic                  is_pop;

  // Configuration register; the single register ignores the byte offset.
  assign pready = 1'b1;
  assign prdata = 32'(capacity);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bmsa_pkg::CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == paddr)) begin
      capacity <= pwdata[4:0];
    end
  end

  // Request acceptance.
  assign accept  = start && !busy;
  assign is_push = command == bmsa_pkg::CMD_PUSH;
  assign is_pop  = (command == bmsa_pkg::CMD_POP) || (command == bmsa_pkg::CMD_POP_AT);

  bmsa_fill_ctrl #(
    .NUM_STACKS (NUM_STACKS),
    .MAX_DEPTH  (MAX_DEPTH)
  ) u_fill (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .command     (command),
    .stack_index (stack_index),
    .capacity    (capacity),
    .sel         (sel)
  );

  // Plate memory access for the chosen stack and slot.
  assign mem_we    = accept && is_push && sel.hit;
  assign mem_re    = accept && is_pop && sel.hit;
  assign mem_addr  = AW'(AW'(sel.stack) * AW'(MAX_DEPTH)) + AW'(sel.slot);
  assign mem_wdata = VALUE_BITS'($unsigned(push_value));

  bmsa_plate_ram #(
    .DEPTH (DEPTH),
    .WIDTH (VALUE_BITS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Status of the request.
  always_comb begin
    status_next = bmsa_pkg::STATUS_OK;
    if (is_push && !sel.hit) begin
      status_next = bmsa_pkg::STATUS_FULL;
    end else if (is_pop && !sel.hit) begin
      status_next = bmsa_pkg::STATUS_EMPTY;
    end
  end

  // Result registers; the popped plate comes straight from the memory port.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_pop    <= is_pop && sel.hit;
      res_status <= status_next;
      res_stack  <= sel.hit ? 4'(sel.stack) : 4'd0;
    end
  end

  assign busy         = done;
  assign popped_value = res_pop ? 32'(mem_rdata) : 32'sd0;
  assign status       = res_status;
  assign placed_stack = res_stack;

endmodule

>>> hdl/bmsa_checker.sv
// ---------------------------------------------------------------------------
// bmsa_checker
// Port-level checks on the request and result timing of the allocator.
// ---------------------------------------------------------------------------
`include "bounded_multi_stack_allocator_unit_defines.svh"

module bmsa_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [31:0] popped_value,
  input logic [1:0]         status,
  input logic [3:0]         placed_stack
);

  // Every accepted request is answered in the following cycle.
  `BMSA_ASSERT_NEXT(a_answer_next, clk, rst, start && !busy, done, "request not answered")

  // A result never appears without a request accepted in the previous cycle.
  `BMSA_ASSERT_NOW(a_no_orphan, clk, rst, done, $past(start && !busy), "result without request")

  // A failed request carries neither a value nor a stack.
  `BMSA_ASSERT_NOW(a_fail_zero, clk, rst, done && (status != bmsa_pkg::STATUS_OK),
    (popped_value == 32'sd0) && (placed_stack == 4'd0), "failed request has payload")

  // The status field only carries defined codes.
  `BMSA_ASSERT_NOW(a_status_code, clk, rst, done,
    (status == bmsa_pkg::STATUS_OK) || (status == bmsa_pkg::STATUS_EMPTY) ||
    (status == bmsa_pkg::STATUS_FULL), "undefined status code")

endmodule

bind bounded_multi_stack_allocator_unit bmsa_checker u_bmsa_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .popped_value (popped_value),
  .status       (status),
  .placed_stack (placed_stack)
);

>>> dv/tb.sv
// ---------------------------------------------------------------------------
// tb: testbench for bounded_multi_stack_allocator_unit
// Drives push, pop and pop-at requests and writes the capacity register
// over APB between phases. Every result is checked against a predictor
// that tracks fill counts and plate values.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         STACKS        = bmsa_pkg::NUM_STACKS_DEF;
  localparam int         DEPTH         = bmsa_pkg::MAX_DEPTH_DEF;
  localparam int         PHASES        = 10;
  localparam int         PHASE_ITEMS   = 74;
  localparam logic [1:0] CMD_IGNORED   = 2'd3;
  localparam logic [1:0] ADDR_CAPACITY = 2'd0;

  // One result of the block: plate removed, status code and stack touched.
  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
    logic [3:0]  stack;
  } plate_result_t;

  // Predicts the stack contents and holds the results still owed.
  class stack_scoreboard;
    logic [31:0]   plates[STACKS][DEPTH];
    int            fill[STACKS];
    logic [4:0]    capacity;
    plate_result_t owed_q[$];
    int            mismatches;

    function new();
      foreach (fill[s]) fill[s] = 0;
      capacity   = bmsa_pkg::CAPACITY_RESET;
      mismatches = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Applies one accepted request to the model and queues its result.
    function void note_request(logic [1:0] cmd, logic [31:0] value, logic [7:0] idx);
      int            limit;
      int            s;
      int            hit;
      plate_result_t r;
      r   = '0;
      hit = -1;
      // A zero capacity acts as one; anything above the depth saturates.
      limit = (capacity == 5'd0) ? 1 : ((capacity > DEPTH) ? DEPTH : int'(capacity));
      case (cmd)
        bmsa_pkg::CMD_PUSH: begin
          for (s = 0; s < STACKS; s++) begin
            if (hit < 0 && fill[s] < limit) hit = s;
          end
          if (hit >= 0) begin
            plates[hit][fill[hit]] = value;
            fill[hit]++;
            r.stack = hit[3:0];
          end else begin
            r.status = bmsa_pkg::STATUS_FULL;
          end
        end
        bmsa_pkg::CMD_POP: begin
          for (s = STACKS - 1; s >= 0; s--) begin
            if (hit < 0 && fill[s] > 0) hit = s;
          end
          if (hit >= 0) begin
            fill[hit]--;
            r.value = plates[hit][fill[hit]];
            r.stack = hit[3:0];
          end else begin
            r.status = bmsa_pkg::STATUS_EMPTY;
          end
        end
        bmsa_pkg::CMD_POP_AT: begin
          if (idx < STACKS && fill[idx] > 0) begin
            fill[idx]--;
            r.value = plates[idx][fill[idx]];
            r.stack = idx[3:0];
          end else begin
            r.status = bmsa_pkg::STATUS_EMPTY;
          end
        end
        default: begin
          // Unused command: no state change, all-zero result.
        end
      endcase
      owed_q.insert(owed_q.size(), r);
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] %s", $realtime, what);
    endfunction

    // Compares one result, field by field, with the oldest owed result.
    function void check_result(plate_result_t got);
      plate_result_t exp;
      if (owed_q.size() == 0) begin
        report($sformatf("result with no request pending: value %h status %0d stack %0d",
                         got.value, got.status, got.stack));
        return;
      end
      exp = owed_q.pop_front();
      if (got.value !== exp.value)
        report($sformatf("popped_value: expected %h, got %h", exp.value, got.value));
      if (got.status !== exp.status)
        report($sformatf("status: expected %0d, got %0d", exp.status, got.status));
      if (got.stack !== exp.stack)
        report($sformatf("placed_stack: expected %0d, got %0d", exp.stack, got.stack));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         command = bmsa_pkg::CMD_PUSH;
  logic signed [31:0] push_value = '0;
  logic [7:0]         stack_index = '0;
  logic               done;
  logic signed [31:0] popped_value;
  logic [1:0]         status;
  logic [3:0]         placed_stack;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [1:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  stack_scoreboard sb = new();

  bounded_multi_stack_allocator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .push_value   (push_value),
    .stack_index  (stack_index),
    .done         (done),
    .popped_value (popped_value),
    .status       (status),
    .placed_stack (placed_stack),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Results are taken at the edge that ends their one-cycle strobe.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result({popped_value, status, placed_stack});
  end

  // Presents one request, waits for its acceptance, then, for a nonzero gap, drops start and idles.
  task automatic send_request(input logic [1:0] cmd, input logic [31:0] value,
                              input logic [7:0] idx, input int gap);
    command     <= cmd;
    push_value  <= value;
    stack_index <= idx;
    start       <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(cmd, value, idx);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops issuing and waits until every owed result has arrived.
  task automatic drain_requests();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write of the capacity register; the block must be idle.
  task automatic write_capacity(input logic [4:0] cap);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_CAPACITY;
    pwdata  <= {27'd0, cap};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.capacity = cap;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Mostly legal stack numbers, with some out of range and the top value.
  function automatic logic [7:0] pick_index();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7)  return 8'($urandom_range(0, STACKS - 1));
    if (r == 7) return 8'($urandom_range(STACKS, 254));
    if (r == 8) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    logic [4:0] caps[PHASES];
    logic [1:0] cmd;
    int         push_pct;
    int         gap;
    int         r;

    caps = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd4, 5'd1, 5'd17, 5'd2, 5'd8, 5'd16};
    caps[8] = 5'($urandom_range(0, 31));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed part at the reset capacity: empty pops, value extremes,
    // the unused command and pop-at beyond the last stack.
    send_request(bmsa_pkg::CMD_POP,    '0,            8'd0,   1);
    send_request(bmsa_pkg::CMD_POP_AT, '0,            8'd0,   0);
    send_request(bmsa_pkg::CMD_POP_AT, '0,            8'd255, 2);
    send_request(CMD_IGNORED,          32'h1234_5678, 8'd3,   0);
    send_request(bmsa_pkg::CMD_PUSH,   32'h7FFF_FFFF, 8'd0,   0);
    send_request(bmsa_pkg::CMD_PUSH,   32'h8000_0000, 8'd0,   1);
    send_request(bmsa_pkg::CMD_PUSH,   32'hFFFF_FFFF, 8'd0,   0);
    send_request(bmsa_pkg::CMD_PUSH,   32'h0000_0000, 8'd0,   0);
    send_request(bmsa_pkg::CMD_POP_AT, '0,            8'd0,   3);
    send_request(bmsa_pkg::CMD_POP_AT, '0,            8'd16,  0);
    send_request(bmsa_pkg::CMD_POP,    '0,            8'd0,   0);
    send_request(CMD_IGNORED,          32'hFFFF_FFFF, 8'hFF,  2);
    send_request(bmsa_pkg::CMD_POP_AT, '0,            8'd0,   0);
    send_request(bmsa_pkg::CMD_POP,    '0,            8'd0,   0);
    send_request(bmsa_pkg::CMD_POP,    '0,            8'd0,   1);

    // Random phases, each at its own capacity; push-heavy and pop-heavy
    // phases alternate so stacks fill, overflow and drain again.
    for (int p = 0; p < PHASES; p++) begin
      drain_requests();
      write_capacity(caps[p]);
      push_pct = (p % 2 == 0) ? 65 : 30;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < push_pct)                 cmd = bmsa_pkg::CMD_PUSH;
        else if (r < push_pct + 2)        cmd = CMD_IGNORED;
        else if ((r - push_pct) % 2 == 0) cmd = bmsa_pkg::CMD_POP;
        else                              cmd = bmsa_pkg::CMD_POP_AT;
        if (p % 3 == 1)                   gap = 0;
        else if ($urandom_range(0, 1))    gap = 0;
        else                              gap = $urandom_range(0, 18);
        send_request(cmd, pick_value(),
                     (cmd == bmsa_pkg::CMD_POP_AT) ? pick_index() :
                                                     8'($urandom_range(0, 255)), gap);
        if ($urandom_range(0, 39) == 0) drain_requests();
      end
    end

    drain_requests();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
